[rtl/vet_pkg.sv]
package vet_pkg;

    localparam int ROWS = 1024;
    localparam int LANES = 4;
    localparam int IN_LANES = 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int LANE_W = 32;
    localparam int VER_W = 32;
    localparam int POS_W = 16;
    localparam int ADD_W = 16;
    localparam int BOUND_W = 31;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    typedef logic signed [LANE_W-1:0] lane_t;
    typedef lane_t [LANES-1:0] lane_vec_t;
    typedef lane_t [IN_LANES-1:0] in_vec_t;

    typedef struct packed {
        logic               is_sync;
        logic [ROW_W-1:0]   row;
        logic [POS_W-1:0]   position;
        logic [ADD_W-1:0]   version_add;
        logic [VER_W-1:0]   client_version;
        logic               force_req;
        in_vec_t            lanes;
    } op_t;

    function automatic lane_t sat_add(lane_t a, lane_t b);
        logic signed [LANE_W:0] s;
        s = {a[LANE_W-1], a} + {b[LANE_W-1], b};
        if (s[LANE_W] != s[LANE_W-1]) begin
            sat_add = s[LANE_W] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}};
        end else begin
            sat_add = s[LANE_W-1:0];
        end
    endfunction

endpackage

[rtl/vet_front.sv]
module vet_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  vet_pkg::op_t           s_op,
    output logic                   q_valid,
    input  logic                   q_ready,
    output vet_pkg::op_t           q_op
);

    vet_pkg::op_t mem_reg [vet_pkg::QDEPTH];
    logic [vet_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [vet_pkg::QPTR_W:0] cnt_reg;
    logic push, pop;

    assign s_ready = cnt_reg != (vet_pkg::QPTR_W+1)'(vet_pkg::QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_op = mem_reg[rd_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= s_op;
        end
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (vet_pkg::QPTR_W+1)'(push) - (vet_pkg::QPTR_W+1)'(pop);
        end
    end

endmodule

[rtl/vet_back.sv]
module vet_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [vet_pkg::BOUND_W-1:0]   bound,
    output logic                          busy,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  vet_pkg::op_t                  q_op,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vet_pkg::POS_W-1:0]     m_out_position,
    output logic [vet_pkg::VER_W-1:0]     m_row_version,
    output vet_pkg::lane_vec_t            m_lanes
);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_OUT} state_t;

    logic [vet_pkg::VER_W-1:0] ver_mem [vet_pkg::ROWS];
    vet_pkg::lane_vec_t        emb_mem [vet_pkg::ROWS];

    state_t state_reg;
    logic [vet_pkg::ROW_W-1:0] clr_reg;
    vet_pkg::op_t op_reg;
    logic [vet_pkg::VER_W-1:0] ver_rd_reg;
    vet_pkg::lane_vec_t emb_rd_reg;
    logic [vet_pkg::VER_W-1:0] diff;
    logic stale;
    vet_pkg::lane_vec_t sum;

    assign q_ready = state_reg == ST_IDLE;
    assign busy = state_reg != ST_IDLE;
    assign diff = ver_rd_reg - op_reg.client_version;
    assign stale = !diff[vet_pkg::VER_W-1] &&
                   (diff[vet_pkg::VER_W-2:0] > bound);

    always_comb begin
        for (int j = 0; j < vet_pkg::LANES; j++) begin
            if (j < vet_pkg::IN_LANES) begin
                sum[j] = vet_pkg::sat_add(emb_rd_reg[j], op_reg.lanes[j]);
            end else begin
                sum[j] = emb_rd_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            ver_rd_reg <= ver_mem[op_reg.row];
            emb_rd_reg <= emb_mem[op_reg.row];
        end
        if (state_reg == ST_CLEAR) begin
            ver_mem[clr_reg] <= '0;
            emb_mem[clr_reg] <= '0;
        end else if (state_reg == ST_EXEC && op_reg.is_sync == vet_pkg::CMD_PUSH) begin
            ver_mem[op_reg.row] <= ver_rd_reg + vet_pkg::VER_W'(op_reg.version_add);
            emb_mem[op_reg.row] <= sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == vet_pkg::ROW_W'(vet_pkg::ROWS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        op_reg <= q_op;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_EXEC;
                ST_EXEC: begin
                    if (op_reg.is_sync == vet_pkg::CMD_SYNC && (op_reg.force_req || stale)) begin
                        m_valid <= 1'b1;
                        m_out_position <= op_reg.position;
                        m_row_version <= ver_rd_reg;
                        m_lanes <= emb_rd_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/versioned_embedding_table.sv]
// Versioned embedding table with 1024 rows of four Q16.16 lanes and a
// 32-bit version per row.
// The s_ channel carries push and sync items; a push adds saturated lane
// deltas and a version increment to its row, a sync returns the row on the
// m_ channel when force_req is set or the signed version lag exceeds the
// staleness bound written on the cfg_ channel.
// Items enter a four-entry queue and are carried out one at a time by a
// read-modify-write sequencer: each item passes through a read state and an
// execute state, and a sync that returns a result then waits in an output
// state. The result is registered at the end of the execute state, which
// follows the read state of the item.
// A sync result holds the sequencer until the receiver takes it, while the
// queue keeps accepting items until it is full.
// After reset the table is cleared one row per cycle until all 1024 rows are
// zero; items queue up meanwhile but are not carried out until it ends.
// Configuration should be written only while the block is idle.
module versioned_embedding_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [9:0]  s_row,
    input  logic [15:0] s_position,
    input  logic [15:0] s_version_add,
    input  logic [31:0] s_client_version,
    input  logic        s_force_req,
    input  logic signed [31:0] s_lane_in_0,
    input  logic signed [31:0] s_lane_in_1,
    input  logic signed [31:0] s_lane_in_2,
    input  logic signed [31:0] s_lane_in_3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_position,
    output logic [31:0] m_row_version,
    output logic signed [31:0] m_lane_out_0,
    output logic signed [31:0] m_lane_out_1,
    output logic signed [31:0] m_lane_out_2,
    output logic signed [31:0] m_lane_out_3
);

    logic [vet_pkg::BOUND_W-1:0] bound_reg;
    vet_pkg::op_t s_op, q_op;
    logic q_valid, q_ready, busy;
    vet_pkg::lane_vec_t m_lanes;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= '0;
        end else if (cfg_valid) begin
            bound_reg <= cfg_data;
        end
    end

    always_comb begin
        s_op.is_sync = s_command;
        s_op.row = s_row;
        s_op.position = s_position;
        s_op.version_add = s_version_add;
        s_op.client_version = s_client_version;
        s_op.force_req = s_force_req;
        s_op.lanes[0] = s_lane_in_0;
        s_op.lanes[1] = s_lane_in_1;
        s_op.lanes[2] = s_lane_in_2;
        s_op.lanes[3] = s_lane_in_3;
    end

    vet_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    vet_back u_back (
        .aclk(aclk), .aresetn(aresetn), .bound(bound_reg), .busy(busy),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_position(m_out_position), .m_row_version(m_row_version),
        .m_lanes(m_lanes)
    );

    assign m_lane_out_0 = m_lanes[0];
    assign m_lane_out_1 = m_lanes[1];
    assign m_lane_out_2 = m_lanes[2];
    assign m_lane_out_3 = m_lanes[3];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_version) && $stable(m_out_position))
        else $error("result changed while stalled");
    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy && !q_ready)
        else $error("sequencer free while a result waits");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !m_valid)
        else $error("queue popped with a pending result");

endmodule
